[rtl/framed_sender_with_ack_retry_top_defines.svh]
// ----------------------------------------------------------------------------
// framed sender assertion macros
// concurrent checks that vanish in synthesis
// ----------------------------------------------------------------------------
`ifndef FRAMED_SENDER_WITH_ACK_RETRY_TOP_DEFINES_SVH
`define FRAMED_SENDER_WITH_ACK_RETRY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FSA_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FSA_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");
`else
`define FSA_ASSERT_IMPLIES(label, ante, cons)
`define FSA_ASSERT_NEVER(label, cond)
`endif

`endif

[rtl/fsa_pkg.sv]
// ----------------------------------------------------------------------------
// fsa_pkg
// types, codes and crc helper shared by the framed sender modules
// ----------------------------------------------------------------------------
package fsa_pkg;

	localparam logic [1:0] ACT_SEND  = 2'd0;
	localparam logic [1:0] ACT_SENDA = 2'd1;
	localparam logic [1:0] ACT_RX    = 2'd2;
	localparam logic [1:0] ACT_TICK  = 2'd3;

	localparam logic KIND_TX  = 1'b0;
	localparam logic KIND_RPT = 1'b1;

	localparam logic [1:0] OUT_DELIVERED = 2'd0;
	localparam logic [1:0] OUT_TIMEOUT   = 2'd1;
	localparam logic [1:0] OUT_BUSY      = 2'd2;

	localparam logic [2:0] REG_DEVICE_ID = 3'd0;
	localparam logic [2:0] REG_TIMEOUT   = 3'd1;
	localparam logic [2:0] REG_RETRY     = 3'd2;
	localparam logic [2:0] REG_LVL_MASK  = 3'd3;
	localparam logic [2:0] REG_VEL_MASK  = 3'd4;
	localparam logic [2:0] REG_WEAK_MASK = 3'd5;

	localparam logic [7:0]  SOF_LO     = 8'hAA;
	localparam logic [7:0]  SOF_HI     = 8'h55;
	localparam logic [7:0]  TYPE_DATA  = 8'h01;
	localparam logic [7:0]  TYPE_ACK   = 8'h81;
	localparam logic [7:0]  DATA_LEN   = 8'd10;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [9:0]  MILLI      = 10'd1000;
	localparam logic [41:0] ROUND_HALF = 42'd32768;
	localparam int          FRAME_BYTES = 20;
	localparam int          ACK_LEN    = 10;
	localparam int          Q_DEPTH    = 2;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] ext_status;
		logic        level_ok;
		logic        velocity_ok;
		logic signed [31:0] level_q16;
		logic signed [31:0] velocity_q16;
		logic [7:0]  rx_byte;
	} fsa_in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        last_byte;
		logic [1:0]  outcome;
		logic [15:0] seq_used;
	} fsa_out_t;

	typedef struct packed {
		logic [15:0] device_id;
		logic [15:0] ack_timeout_ms;
		logic [3:0]  max_retry;
		logic [15:0] level_valid_mask;
		logic [15:0] velocity_valid_mask;
		logic [15:0] signal_weak_mask;
	} fsa_cfg_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] status;
		logic [31:0] level_mm;
		logic [31:0] vel_mm;
		logic [7:0]  rx_byte;
	} fsa_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fsa_qstat_t;

	function automatic logic [15:0] crc16_upd(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		end
		return x;
	endfunction

endpackage

[rtl/fsa_front.sv]
// ----------------------------------------------------------------------------
// fsa_front
// takes requests, builds status and converts q16.16 to rounded milli units
// ----------------------------------------------------------------------------
module fsa_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fsa_pkg::fsa_in_t   in_item,
	input  fsa_pkg::fsa_cfg_t  cfg,
	input  fsa_pkg::fsa_qstat_t qstat,
	output logic               push,
	output fsa_pkg::fsa_cmd_t  push_cmd
);
	import fsa_pkg::*;

	logic        v_s1, v_s2;
	fsa_in_t     item_s1;
	logic [31:0] lmag, vmag;
	logic [41:0] lprod_s2, vprod_s2;
	logic        lneg_s2, vneg_s2;
	logic [15:0] status_s2;
	logic [1:0]  action_s2;
	logic [7:0]  rx_s2;
	logic [41:0] lr, vr;

	assign in_stall = v_s1 | v_s2 | qstat.full;

	always_comb begin
		lmag = item_s1.level_q16[31] ? (32'd0 - item_s1.level_q16) : item_s1.level_q16;
		vmag = item_s1.velocity_q16[31] ? (32'd0 - item_s1.velocity_q16) : item_s1.velocity_q16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid & ~in_stall;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (push) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid & ~in_stall) begin
			item_s1 <= in_item;
		end
		if (v_s1) begin
			lprod_s2  <= {10'd0, lmag} * {32'd0, MILLI};
			vprod_s2  <= {10'd0, vmag} * {32'd0, MILLI};
			lneg_s2   <= item_s1.level_q16[31];
			vneg_s2   <= item_s1.velocity_q16[31];
			status_s2 <= item_s1.ext_status
				| (item_s1.level_ok ? cfg.level_valid_mask : cfg.signal_weak_mask)
				| (item_s1.velocity_ok ? cfg.velocity_valid_mask : 16'd0);
			action_s2 <= item_s1.action;
			rx_s2     <= item_s1.rx_byte;
		end
	end

	always_comb begin
		lr = (lprod_s2 + ROUND_HALF) >> 16;
		vr = (vprod_s2 + ROUND_HALF) >> 16;
		push = v_s2 & ~qstat.full;
		push_cmd.action   = action_s2;
		push_cmd.status   = status_s2;
		push_cmd.level_mm = lneg_s2 ? (32'd0 - lr[31:0]) : lr[31:0];
		push_cmd.vel_mm   = vneg_s2 ? (32'd0 - vr[31:0]) : vr[31:0];
		push_cmd.rx_byte  = rx_s2;
	end

endmodule

[rtl/fsa_queue.sv]
// ----------------------------------------------------------------------------
// fsa_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module fsa_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fsa_pkg::fsa_cmd_t   push_cmd,
	input  logic                pop,
	output fsa_pkg::fsa_cmd_t   pop_cmd,
	output fsa_pkg::fsa_qstat_t qstat
);
	import fsa_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);

	fsa_cmd_t        ent_q [Q_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign qstat.full  = (cnt_q == (PW+1)'(Q_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_cmd     = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

[rtl/fsa_back.sv]
// ----------------------------------------------------------------------------
// fsa_back
// frame build, crc, transmit, ack hunt and retry timer
// ----------------------------------------------------------------------------
module fsa_back #(
	parameter int TICK_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fsa_pkg::fsa_cfg_t   cfg,
	input  fsa_pkg::fsa_qstat_t qstat,
	input  fsa_pkg::fsa_cmd_t   cmd,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output fsa_pkg::fsa_out_t   out_item
);
	import fsa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CRC  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_RPT  = 2'd3;
	localparam logic [32:0] TICK_MAX = (33'd1 << TICK_WIDTH) - 33'd1;

	logic [1:0]  state_q;
	logic [4:0]  idx_q;
	logic        plain_q;
	logic [15:0] seq_q;
	logic        await_q;
	logic [3:0]  attempts_q;
	logic [TICK_WIDTH-1:0] elapsed_q;
	logic [3:0]  ack_idx_q;
	logic        out_v_q;
	fsa_out_t    out_q;

	// stored frame fields
	logic [15:0] f_id_q, f_seq_q, f_status_q, f_crc_q;
	logic [31:0] f_level_q, f_vel_q;

	// ack candidate
	logic [7:0]  a_type_q, a_len_q, a_crclo_q;
	logic [15:0] a_id_q, a_seq_q, a_crc_q;

	logic        slot_free;
	logic [7:0]  fbyte;
	logic [TICK_WIDTH-1:0] el_next;
	logic [32:0] tmo, lim;
	logic        reached;
	logic        ack_ok;
	logic        load_out;

	assign slot_free = ~out_v_q | ~out_stall;
	assign pop       = (state_q == ST_IDLE) & ~qstat.empty & slot_free;
	assign out_valid = out_v_q;
	assign out_item  = out_q;

	always_comb begin
		unique case (idx_q)
			5'd0:    fbyte = SOF_LO;
			5'd1:    fbyte = SOF_HI;
			5'd2:    fbyte = TYPE_DATA;
			5'd3:    fbyte = f_id_q[7:0];
			5'd4:    fbyte = f_id_q[15:8];
			5'd5:    fbyte = f_seq_q[7:0];
			5'd6:    fbyte = f_seq_q[15:8];
			5'd7:    fbyte = DATA_LEN;
			5'd8:    fbyte = f_status_q[7:0];
			5'd9:    fbyte = f_status_q[15:8];
			5'd10:   fbyte = f_level_q[7:0];
			5'd11:   fbyte = f_level_q[15:8];
			5'd12:   fbyte = f_level_q[23:16];
			5'd13:   fbyte = f_level_q[31:24];
			5'd14:   fbyte = f_vel_q[7:0];
			5'd15:   fbyte = f_vel_q[15:8];
			5'd16:   fbyte = f_vel_q[23:16];
			5'd17:   fbyte = f_vel_q[31:24];
			5'd18:   fbyte = f_crc_q[7:0];
			5'd19:   fbyte = f_crc_q[15:8];
			default: fbyte = 8'h00;
		endcase
	end

	always_comb begin
		el_next = (elapsed_q == {TICK_WIDTH{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
		tmo     = (cfg.ack_timeout_ms == 16'd0) ? 33'd1 : {17'd0, cfg.ack_timeout_ms};
		lim     = (tmo > TICK_MAX) ? TICK_MAX : tmo;
		reached = (33'(el_next) >= lim);
		// final ack byte arrives with the check
		ack_ok  = (a_type_q == TYPE_ACK) && (a_len_q == 8'd0)
			&& (a_id_q == cfg.device_id) && (a_seq_q == seq_q)
			&& ({cmd.rx_byte, a_crclo_q} == a_crc_q);
	end

	// a new result enters the output register this cycle
	always_comb begin
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pop && await_q) begin
					unique case (cmd.action)
						ACT_SEND, ACT_SENDA: load_out = 1'b1;
						ACT_RX:              load_out = (ack_idx_q == 4'd9) && ack_ok;
						ACT_TICK:            load_out = reached && !(attempts_q < cfg.max_retry);
						default: ;
					endcase
				end
			end
			ST_EMIT, ST_RPT: load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && (cmd.action == ACT_SEND || cmd.action == ACT_SENDA) && !await_q) begin
			f_id_q     <= cfg.device_id;
			f_seq_q    <= seq_q;
			f_status_q <= cmd.status;
			f_level_q  <= cmd.level_mm;
			f_vel_q    <= cmd.vel_mm;
			f_crc_q    <= CRC_INIT;
		end else if (state_q == ST_CRC) begin
			f_crc_q <= crc16_upd(f_crc_q, fbyte);
		end
		if (pop && cmd.action == ACT_RX && await_q) begin
			unique case (ack_idx_q)
				4'd2:    a_type_q     <= cmd.rx_byte;
				4'd3:    a_id_q[7:0]  <= cmd.rx_byte;
				4'd4:    a_id_q[15:8] <= cmd.rx_byte;
				4'd5:    a_seq_q[7:0] <= cmd.rx_byte;
				4'd6:    a_seq_q[15:8] <= cmd.rx_byte;
				4'd7:    a_len_q      <= cmd.rx_byte;
				4'd8:    a_crclo_q    <= cmd.rx_byte;
				default: ;
			endcase
			if (ack_idx_q == 4'd2) begin
				a_crc_q <= crc16_upd(CRC_INIT, cmd.rx_byte);
			end else if (ack_idx_q >= 4'd3 && ack_idx_q <= 4'd7) begin
				a_crc_q <= crc16_upd(a_crc_q, cmd.rx_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			plain_q    <= 1'b0;
			seq_q      <= '0;
			await_q    <= 1'b0;
			attempts_q <= '0;
			elapsed_q  <= '0;
			ack_idx_q  <= '0;
			out_v_q    <= 1'b0;
			out_q      <= '0;
		end else begin
			out_v_q <= load_out | (out_v_q & out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (cmd.action)
							ACT_SEND, ACT_SENDA: begin
								if (await_q) begin
									out_q   <= '{KIND_RPT, 8'd0, 1'b0, OUT_BUSY, seq_q};
								end else begin
									plain_q <= (cmd.action == ACT_SEND);
									idx_q   <= 5'd2;
									state_q <= ST_CRC;
									if (cmd.action == ACT_SENDA) begin
										await_q    <= 1'b1;
										attempts_q <= '0;
										elapsed_q  <= '0;
										ack_idx_q  <= '0;
									end
								end
							end
							ACT_RX: begin
								if (await_q) begin
									priority if (ack_idx_q == 4'd0) begin
										if (cmd.rx_byte == SOF_LO) ack_idx_q <= 4'd1;
									end else if (ack_idx_q == 4'd1) begin
										ack_idx_q <= (cmd.rx_byte == SOF_HI) ? 4'd2 : 4'd0;
									end else if (ack_idx_q == 4'd9) begin
										ack_idx_q <= '0;
										if (ack_ok) begin
											out_q   <= '{KIND_RPT, 8'd0, 1'b0, OUT_DELIVERED, seq_q};
											seq_q   <= seq_q + 16'd1;
											await_q <= 1'b0;
										end
									end else begin
										ack_idx_q <= ack_idx_q + 4'd1;
									end
								end
							end
							ACT_TICK: begin
								if (await_q) begin
									if (!reached) begin
										elapsed_q <= el_next;
									end else if (attempts_q < cfg.max_retry) begin
										attempts_q <= attempts_q + 4'd1;
										elapsed_q  <= '0;
										ack_idx_q  <= '0;
										idx_q      <= '0;
										state_q    <= ST_EMIT;
									end else begin
										await_q   <= 1'b0;
										elapsed_q <= '0;
										ack_idx_q <= '0;
										out_q     <= '{KIND_RPT, 8'd0, 1'b0, OUT_TIMEOUT, seq_q};
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_CRC: begin
					if (idx_q == 5'd17) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_q   <= '{KIND_TX, fbyte, (idx_q == 5'(FRAME_BYTES - 1)),
							OUT_DELIVERED, seq_q};
						if (idx_q == 5'(FRAME_BYTES - 1)) begin
							state_q <= (plain_q && !await_q) ? ST_RPT : ST_IDLE;
						end else begin
							idx_q <= idx_q + 5'd1;
						end
					end
				end
				ST_RPT: begin
					if (slot_free) begin
						out_q   <= '{KIND_RPT, 8'd0, 1'b0, OUT_DELIVERED, seq_q};
						seq_q   <= seq_q + 16'd1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/framed_sender_with_ack_retry_top.sv]
// ----------------------------------------------------------------------------
// framed_sender_with_ack_retry_top
// Sends 20-byte CRC16 frames and waits for a matching ACK with timed
// resends. The front takes one request through capture, multiply by 1000,
// round and push before it takes the next, so it holds one request at a
// time; a two-entry queue sits behind it. The back pops a queued request
// only when it is idle and its output register is free. A plain send pops
// the request, runs a byte-serial CRC over the frame from type to velocity,
// emits the 20 bytes and then one report; an acknowledged send reports on
// its ACK or timeout instead. A received byte, a tick or a busy refusal is
// handled at its pop, and a tick that resends emits the frame again.
// ----------------------------------------------------------------------------
`include "framed_sender_with_ack_retry_top_defines.svh"

module framed_sender_with_ack_retry_top #(
	parameter int TICK_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fsa_pkg::fsa_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output fsa_pkg::fsa_out_t out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import fsa_pkg::*;

	fsa_cfg_t   cfg_q;
	fsa_qstat_t qstat;
	fsa_cmd_t   push_cmd, pop_cmd;
	logic       push, pop;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{16'd1, 16'd100, 4'd3, 16'd1, 16'd2, 16'd4};
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_DEVICE_ID: cfg_q.device_id           <= pwdata[15:0];
				REG_TIMEOUT:   cfg_q.ack_timeout_ms      <= pwdata[15:0];
				REG_RETRY:     cfg_q.max_retry           <= pwdata[3:0];
				REG_LVL_MASK:  cfg_q.level_valid_mask    <= pwdata[15:0];
				REG_VEL_MASK:  cfg_q.velocity_valid_mask <= pwdata[15:0];
				REG_WEAK_MASK: cfg_q.signal_weak_mask    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEVICE_ID: prdata = {16'd0, cfg_q.device_id};
			REG_TIMEOUT:   prdata = {16'd0, cfg_q.ack_timeout_ms};
			REG_RETRY:     prdata = {28'd0, cfg_q.max_retry};
			REG_LVL_MASK:  prdata = {16'd0, cfg_q.level_valid_mask};
			REG_VEL_MASK:  prdata = {16'd0, cfg_q.velocity_valid_mask};
			REG_WEAK_MASK: prdata = {16'd0, cfg_q.signal_weak_mask};
			default:       prdata = 32'd0;
		endcase
	end

	fsa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	fsa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.qstat    (qstat)
	);

	fsa_back #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.cmd       (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	`FSA_ASSERT_NEVER(a_no_pop_empty, pop && qstat.empty)
	`FSA_ASSERT_NEVER(a_no_push_full, push && qstat.full)
	`FSA_ASSERT_IMPLIES(a_last_is_tx, out_valid && out_item.last_byte, out_item.kind == KIND_TX)

endmodule
